### rtl/kwdf_pkg.sv
// Shared constants, codes and types for the knob window deadband filter.
// Depends on nothing; every other rtl file imports it.
`default_nettype none

package kwdf_pkg;

	// Knob and window geometry; the window length is a power of two so the
	// average is a plain shift and the window address is {knob, slot}.
	localparam int NUM_KNOBS  = 4;
	localparam int WINDOW_LEN = 8;

	localparam int KNOB_W    = 2;
	localparam int SAMPLE_W  = 8;
	localparam int SLOT_W    = $clog2(WINDOW_LEN);
	localparam int WIN_SHIFT = SLOT_W;
	localparam int SUM_W     = SAMPLE_W + SLOT_W;
	localparam int ADDR_W    = KNOB_W + SLOT_W;
	localparam int MEM_DEPTH = 1 << ADDR_W;

	localparam logic [KNOB_W-1:0] KNOB_LAST = KNOB_W'(NUM_KNOBS - 1);
	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW_LEN - 1);

	localparam logic [SAMPLE_W-1:0] SAMPLE_FULL = 8'hFF;

	localparam logic OP_STORE = 1'b0;
	localparam logic OP_EVAL  = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SUM,
		ST_LAST,
		ST_DECIDE,
		ST_EMIT
	} kwdf_state_t;

	typedef struct packed {
		logic clear;
		logic add;
	} kwdf_acc_ctrl_t;

	typedef struct packed {
		logic                change;
		logic [SAMPLE_W-1:0] value;
	} kwdf_decision_t;

endpackage

`default_nettype wire

### rtl/kwdf_window_mem.sv
// Sample window store: one write port, one registered read port.
// Per-entry written flags make unwritten entries read as zero. Uses kwdf_pkg.
`default_nettype none

module kwdf_window_mem (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [kwdf_pkg::ADDR_W-1:0]   wr_addr,
	input  logic [kwdf_pkg::SAMPLE_W-1:0] wr_data,
	input  logic                          rd_en,
	input  logic [kwdf_pkg::ADDR_W-1:0]   rd_addr,
	output logic [kwdf_pkg::SAMPLE_W-1:0] rd_data
);
	import kwdf_pkg::*;

	logic [SAMPLE_W-1:0]  mem_q [MEM_DEPTH];
	logic [MEM_DEPTH-1:0] written_q;
	logic [SAMPLE_W-1:0]  rd_raw_q;
	logic                 rd_hit_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_raw_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
			rd_hit_q  <= 1'b0;
		end else begin
			if (wr_en) begin
				written_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_hit_q <= written_q[rd_addr];
			end
		end
	end

	// unwritten entries read as zero through their cleared written flag
	assign rd_data = rd_hit_q ? rd_raw_q : '0;

endmodule

`default_nettype wire

### rtl/kwdf_eval_unit.sv
// Shared accumulate and deadband compare unit, reused for every knob.
// Sums one window entry per cycle, then decides the held value move. Uses kwdf_pkg.
`default_nettype none

module kwdf_eval_unit (
	input  logic                           clk,
	input  kwdf_pkg::kwdf_acc_ctrl_t       ctrl,
	input  logic [kwdf_pkg::SAMPLE_W-1:0]  add_data,
	input  logic [kwdf_pkg::SAMPLE_W-1:0]  held,
	output kwdf_pkg::kwdf_decision_t       decision
);
	import kwdf_pkg::*;

	logic [SUM_W-1:0]    acc_q;
	logic [SAMPLE_W-1:0] avg_floor;
	logic [SAMPLE_W-1:0] avg_ceil;

	always_ff @(posedge clk) begin
		if (ctrl.clear) begin
			acc_q <= '0;
		end else if (ctrl.add) begin
			acc_q <= acc_q + SUM_W'(add_data);
		end
	end

	// Moving up by a truncated quotient lands on floor(sum / len); moving
	// down lands on ceil(sum / len). The deadband is the gap between them.
	// A full-scale sum has no remainder, so the ceiling never overflows.
	always_comb begin
		avg_floor = acc_q[SUM_W-1:WIN_SHIFT];
		avg_ceil  = avg_floor + SAMPLE_W'(|acc_q[WIN_SHIFT-1:0]);
		decision  = '0;
		if (avg_floor > held) begin
			decision.change = 1'b1;
			decision.value  = avg_floor;
		end else if (avg_ceil < held) begin
			decision.change = 1'b1;
			decision.value  = avg_ceil;
		end else begin
			decision.value  = held;
		end
	end

endmodule

`default_nettype wire

### rtl/knob_window_deadband_filter_core.sv
// Knob window deadband filter: top level with sequencer, held values and output register.
// Store beat: taken back to back. Evaluate beat: each knob's window is summed
// through the shared accumulator, one window read per cycle, then the knobs are walked
// to emit changes, holding while the output stalls; the input stalls throughout.
// Reset clears counters, held values and window written flags, so every window reads zero.
`default_nettype none

module knob_window_deadband_filter_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          opcode,
	input  logic [kwdf_pkg::KNOB_W-1:0]   knob_select,
	input  logic [kwdf_pkg::SAMPLE_W-1:0] sample,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [kwdf_pkg::KNOB_W-1:0]   knob_index,
	output logic [kwdf_pkg::SAMPLE_W-1:0] knob_value,
	output logic                          last
);
	import kwdf_pkg::*;

	kwdf_state_t         state_q, state_d;
	logic [KNOB_W-1:0]   knob_q;      // knob walk for both sum and emit phases
	logic [SLOT_W-1:0]   idx_q;       // window entry being read
	logic [KNOB_W-1:0]   rr_q;        // round-robin store counter
	logic [SLOT_W-1:0]   slot_q;      // shared window slot
	logic [SAMPLE_W-1:0] held_q [NUM_KNOBS];
	logic [NUM_KNOBS-1:0] changed_q;
	logic                rd_vld_s1;

	logic                out_valid_q;
	logic [KNOB_W-1:0]   knob_index_q;
	logic [SAMPLE_W-1:0] knob_value_q;
	logic                last_q;

	logic                in_take;
	logic                store_take;
	logic                knob_ok;
	logic                mem_wr_en;
	logic                mem_rd_en;
	logic [SAMPLE_W-1:0] mem_rd_data;
	logic                out_free;
	logic                emit_step;
	logic                emit_load;
	logic                later_change;
	kwdf_acc_ctrl_t      acc_ctrl;
	kwdf_decision_t      decision;

	assign in_stall   = (state_q != ST_IDLE);
	assign in_take    = in_valid && !in_stall;
	assign store_take = in_take && (opcode == OP_STORE);
	assign knob_ok    = ((KNOB_W+1)'(knob_select) < (KNOB_W+1)'(NUM_KNOBS));
	assign mem_wr_en  = store_take && knob_ok;
	assign out_free   = !out_valid_q || !out_stall;

	// Window store, addressed {knob, slot}; written inverted.
	kwdf_window_mem u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (mem_wr_en),
		.wr_addr ({knob_select, slot_q}),
		.wr_data (SAMPLE_FULL - sample),
		.rd_en   (mem_rd_en),
		.rd_addr ({knob_q, idx_q}),
		.rd_data (mem_rd_data)
	);

	// Shared accumulator and deadband compare.
	kwdf_eval_unit u_eval (
		.clk      (clk),
		.ctrl     (acc_ctrl),
		.add_data (mem_rd_data),
		.held     (held_q[knob_q]),
		.decision (decision)
	);

	// Any change left for a higher knob decides whether this beat is the last.
	always_comb begin
		later_change = 1'b0;
		for (int i = 0; i < NUM_KNOBS; i++) begin
			if (changed_q[i] && (KNOB_W'(i) > knob_q)) begin
				later_change = 1'b1;
			end
		end
	end

	// Sequencer: idle -> sum window -> collect last read -> decide, per knob;
	// after the last knob, walk the change flags and emit.
	always_comb begin
		state_d        = state_q;
		mem_rd_en      = 1'b0;
		acc_ctrl.clear = 1'b0;
		acc_ctrl.add   = 1'b0;
		emit_step      = 1'b0;
		emit_load      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				acc_ctrl.clear = 1'b1;
				if (in_take && (opcode == OP_EVAL)) begin
					state_d = ST_SUM;
				end
			end
			ST_SUM: begin
				mem_rd_en    = 1'b1;
				acc_ctrl.add = rd_vld_s1;
				if (idx_q == SLOT_LAST) begin
					state_d = ST_LAST;
				end
			end
			ST_LAST: begin
				acc_ctrl.add = rd_vld_s1;
				state_d      = ST_DECIDE;
			end
			ST_DECIDE: begin
				acc_ctrl.clear = 1'b1;
				state_d        = (knob_q == KNOB_LAST) ? ST_EMIT : ST_SUM;
			end
			ST_EMIT: begin
				// skip unchanged knobs; hold on a change until the output frees
				emit_step = !changed_q[knob_q] || out_free;
				emit_load = changed_q[knob_q] && out_free;
				if (emit_step && (knob_q == KNOB_LAST)) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			knob_q      <= '0;
			idx_q       <= '0;
			rr_q        <= '0;
			slot_q      <= '0;
			changed_q   <= '0;
			rd_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
			for (int k = 0; k < NUM_KNOBS; k++) begin
				held_q[k] <= '0;
			end
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= mem_rd_en;

			// advance the round robin; the slot moves after every full round
			if (store_take) begin
				if (rr_q == KNOB_LAST) begin
					rr_q   <= '0;
					slot_q <= (slot_q == SLOT_LAST) ? '0 : slot_q + SLOT_W'(1);
				end else begin
					rr_q <= rr_q + KNOB_W'(1);
				end
			end

			if (mem_rd_en) begin
				idx_q <= (idx_q == SLOT_LAST) ? '0 : idx_q + SLOT_W'(1);
			end

			if (state_q == ST_DECIDE) begin
				changed_q[knob_q] <= decision.change;
				if (decision.change) begin
					held_q[knob_q] <= decision.value;
				end
			end

			if ((state_q == ST_DECIDE) || emit_step) begin
				knob_q <= (knob_q == KNOB_LAST) ? '0 : knob_q + KNOB_W'(1);
			end

			if (emit_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output payload: load only when the register is free
	always_ff @(posedge clk) begin
		if (emit_load) begin
			knob_index_q <= knob_q;
			knob_value_q <= held_q[knob_q];
			last_q       <= !later_change;
		end
	end

	assign out_valid  = out_valid_q;
	assign knob_index = knob_index_q;
	assign knob_value = knob_value_q;
	assign last       = last_q;

endmodule

`default_nettype wire
